>>> rtl/core/b5tl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b5tl_pkg
// Types, constants and helpers shared by the big5 text cursor layout core.
// ----------------------------------------------------------------------------
package b5tl_pkg;

  // cursor coordinate width, saturation point of the cursor and position sums
  localparam int unsigned CoordBits = 13;
  // width that holds any sum of a coordinate and a register without overflow
  localparam int unsigned SumW      = CoordBits + 5;
  localparam int unsigned PosW      = 13;
  localparam int unsigned IdxW      = 14;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned RegIdxW   = 3;

  localparam logic [SumW-1:0] CoordMaxExt = SumW'((1 << CoordBits) - 1);

  // byte code ranges
  localparam logic [ByteW-1:0] SingleLo     = 8'h20;
  localparam logic [ByteW-1:0] SingleHi     = 8'h7E;
  localparam logic [ByteW-1:0] Big5Lo       = 8'hA1;
  localparam logic [ByteW-1:0] Big5Hi       = 8'hFE;
  localparam logic [ByteW-1:0] TrailLowLo   = 8'h40;
  localparam logic [ByteW-1:0] TrailLowHi   = 8'h7E;
  localparam logic [ByteW-1:0] TrailHighOff = 8'h62;
  localparam logic [ByteW-1:0] Big5RowLen   = 8'h9D;

  // register indexes
  localparam logic [RegIdxW-1:0] RegWindowLeft   = 3'd0;
  localparam logic [RegIdxW-1:0] RegWindowTop    = 3'd1;
  localparam logic [RegIdxW-1:0] RegWindowWidth  = 3'd2;
  localparam logic [RegIdxW-1:0] RegWindowHeight = 3'd3;
  localparam logic [RegIdxW-1:0] RegSingleAdv    = 3'd4;
  localparam logic [RegIdxW-1:0] RegDoubleAdv    = 3'd5;
  localparam logic [RegIdxW-1:0] RegRowHeight    = 3'd6;
  localparam logic [RegIdxW-1:0] RegLinePitch    = 3'd7;

  typedef logic [CoordBits-1:0] coord_t;

  typedef struct packed {
    logic [11:0] window_left;
    logic [11:0] window_top;
    logic [12:0] window_width;
    logic [12:0] window_height;
    logic [7:0]  single_advance;
    logic [7:0]  double_advance;
    logic [7:0]  row_height;
    logic [8:0]  line_pitch;
  } cfg_t;

  typedef struct packed {
    logic             lead_pending;
    logic [ByteW-1:0] lead_value;
    coord_t           cursor_x;
    coord_t           cursor_y;
  } state_t;

  typedef struct packed {
    logic            glyph_set;
    logic [IdxW-1:0] glyph_index;
    logic [PosW-1:0] pos_x;
    logic [PosW-1:0] pos_y;
    logic            scroll_request;
    logic            code_ok;
  } result_t;

  function automatic coord_t sat_coord(input logic [SumW-1:0] v);
    return (v > CoordMaxExt) ? coord_t'(CoordMaxExt) : coord_t'(v);
  endfunction

endpackage

>>> rtl/core/b5tl_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b5tl_step
// Layout logic for one stream item: byte decode, wrap and line feed,
// glyph index and position, next cursor state.
// ----------------------------------------------------------------------------
module b5tl_step (
  input  b5tl_pkg::cfg_t            cfg_i,
  input  b5tl_pkg::state_t          state_i,
  input  logic                      cmd_i,
  input  logic [b5tl_pkg::ByteW-1:0] byte_i,
  output b5tl_pkg::state_t          state_o,
  output logic                      res_valid_o,
  output b5tl_pkg::result_t         res_o
);
  import b5tl_pkg::*;

  logic            is_single;
  logic [7:0]      move;
  logic [SumW-1:0] wrap_sum;
  logic [SumW-1:0] next_y;
  logic            do_lf;
  logic            hit_bottom;
  coord_t          cx_w;
  coord_t          cy_w;
  coord_t          cx_adv;
  logic            lead_ok;
  logic            trail_low;
  logic            trail_high;
  logic            dbl_ok;
  logic [IdxW-1:0] lead_off;
  logic [IdxW-1:0] dbl_base;
  logic [IdxW-1:0] trail_off;
  logic [IdxW-1:0] dbl_idx;

  always_comb begin
    is_single = (byte_i >= SingleLo) && (byte_i <= SingleHi);
    move = state_i.lead_pending ? cfg_i.double_advance : cfg_i.single_advance;

    // wrap check, then line feed with scroll at the window bottom
    wrap_sum   = SumW'(state_i.cursor_x) + SumW'(move);
    do_lf      = wrap_sum >= SumW'(cfg_i.window_width);
    next_y     = SumW'(state_i.cursor_y) + SumW'(cfg_i.line_pitch);
    hit_bottom = (next_y + SumW'(cfg_i.row_height)) >= SumW'(cfg_i.window_height);
    cx_w       = do_lf ? '0 : state_i.cursor_x;
    cy_w       = (do_lf && !hit_bottom) ? sat_coord(next_y) : state_i.cursor_y;
    cx_adv     = sat_coord(SumW'(cx_w) + SumW'(move));

    // double-byte index: row of 157 codes per lead byte
    lead_ok    = (state_i.lead_value >= Big5Lo) && (state_i.lead_value <= Big5Hi);
    trail_low  = (byte_i >= TrailLowLo) && (byte_i <= TrailLowHi);
    trail_high = (byte_i >= Big5Lo) && (byte_i <= Big5Hi);
    dbl_ok     = lead_ok && (trail_low || trail_high);
    lead_off   = IdxW'(state_i.lead_value - Big5Lo);
    dbl_base   = IdxW'(lead_off * IdxW'(Big5RowLen));
    trail_off  = trail_low ? IdxW'(byte_i - TrailLowLo) : IdxW'(byte_i - TrailHighOff);
    dbl_idx    = dbl_ok ? (dbl_base + trail_off) : '0;

    res_o.glyph_set      = state_i.lead_pending;
    res_o.glyph_index    = state_i.lead_pending ? dbl_idx : IdxW'(byte_i - SingleLo);
    res_o.pos_x          = PosW'(sat_coord(SumW'(cx_w) + SumW'(cfg_i.window_left)));
    res_o.pos_y          = PosW'(sat_coord(SumW'(cy_w) + SumW'(cfg_i.window_top)));
    res_o.scroll_request = do_lf && hit_bottom;
    res_o.code_ok        = state_i.lead_pending ? dbl_ok : 1'b1;

    state_o     = state_i;
    res_valid_o = 1'b0;
    if (cmd_i) begin
      // clear keeps a pending lead byte
      state_o.cursor_x = '0;
      state_o.cursor_y = '0;
    end else if (!state_i.lead_pending) begin
      if (is_single) begin
        state_o.cursor_x = cx_adv;
        state_o.cursor_y = cy_w;
        res_valid_o      = 1'b1;
      end else begin
        state_o.lead_pending = 1'b1;
        state_o.lead_value   = byte_i;
      end
    end else begin
      state_o.lead_pending = 1'b0;
      state_o.cursor_y     = cy_w;
      if (state_i.lead_value < SingleLo) begin
        // control lead: wrap only, nothing drawn
        state_o.cursor_x = cx_w;
      end else begin
        state_o.cursor_x = cx_adv;
        res_valid_o      = 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/big5_text_cursor_layout_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// big5_text_cursor_layout_core
// Places one-byte and big5 double-byte glyphs of a text stream in a window.
// ----------------------------------------------------------------------------
// The input stream carries one text byte per transfer in tdata; tuser set
// moves the cursor back to the window origin instead. Each drawn glyph gives
// one output transfer with its font in tuser and its index, screen position,
// scroll flag and code flag in tdata. Lead bytes, clears and control codes
// give no transfer.
// A transfer is taken into an input register, worked on there by the layout
// logic, and written to a two-entry result queue that drives the output.
// Throughput is one byte per cycle while the queue has room; the cursor
// update of the layout logic is combinational, so consecutive bytes
// follow without gaps.
// When the receiver stalls the queue fills; once it holds two results and
// another item waits in the input register, s_axis_tready drops until a
// result is taken. Reset clears the cursor, the pending lead byte and the
// queue and loads the register defaults (640 x 480 window, 8/16 advances,
// 16 pitch).
// Registers sit on the APB port at byte address 4*index; the user must write
// them only while the stream is idle, the block itself does not enforce this.
// ----------------------------------------------------------------------------
module big5_text_cursor_layout_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // text_byte
  input  logic        s_axis_tuser,   // cmd
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // glyph_index, pos_x, pos_y, scroll_request, code_ok
  output logic        m_axis_tuser    // glyph_set
);
  import b5tl_pkg::*;

  cfg_t             cfg_q;
  state_t           state_q;
  state_t           state_d;
  logic             stage_valid_q;
  logic             stage_cmd_q;
  logic [ByteW-1:0] stage_byte_q;
  logic             res_valid;
  result_t          res;
  result_t          fifo_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             push;
  logic             pop;
  logic             adv;
  logic             cfg_wr;
  logic [RegIdxW-1:0] reg_idx;
  result_t          head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_left    <= '0;
      cfg_q.window_top     <= '0;
      cfg_q.window_width   <= 13'd640;
      cfg_q.window_height  <= 13'd480;
      cfg_q.single_advance <= 8'd8;
      cfg_q.double_advance <= 8'd16;
      cfg_q.row_height     <= 8'd16;
      cfg_q.line_pitch     <= 9'd16;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegWindowLeft:   cfg_q.window_left    <= pwdata[11:0];
        RegWindowTop:    cfg_q.window_top     <= pwdata[11:0];
        RegWindowWidth:  cfg_q.window_width   <= pwdata[12:0];
        RegWindowHeight: cfg_q.window_height  <= pwdata[12:0];
        RegSingleAdv:    cfg_q.single_advance <= pwdata[7:0];
        RegDoubleAdv:    cfg_q.double_advance <= pwdata[7:0];
        RegRowHeight:    cfg_q.row_height     <= pwdata[7:0];
        RegLinePitch:    cfg_q.line_pitch     <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegWindowLeft:   prdata = 32'(cfg_q.window_left);
      RegWindowTop:    prdata = 32'(cfg_q.window_top);
      RegWindowWidth:  prdata = 32'(cfg_q.window_width);
      RegWindowHeight: prdata = 32'(cfg_q.window_height);
      RegSingleAdv:    prdata = 32'(cfg_q.single_advance);
      RegDoubleAdv:    prdata = 32'(cfg_q.double_advance);
      RegRowHeight:    prdata = 32'(cfg_q.row_height);
      RegLinePitch:    prdata = 32'(cfg_q.line_pitch);
      default:         prdata = '0;
    endcase
  end

  // the input register moves on when the queue has room for its result
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign adv           = stage_valid_q && ((cnt_q != 2'd2) || pop);
  assign s_axis_tready = !stage_valid_q || adv;
  assign push          = adv && res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      stage_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      stage_cmd_q  <= s_axis_tuser;
      stage_byte_q <= s_axis_tdata;
    end
  end

  b5tl_step u_step (
    .cfg_i       (cfg_q),
    .state_i     (state_q),
    .cmd_i       (stage_cmd_q),
    .byte_i      (stage_byte_q),
    .state_o     (state_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (adv) begin
      state_q <= state_d;
    end
  end

  // two-entry result queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  assign head          = fifo_q[rd_ptr_q];
  assign m_axis_tvalid = cnt_q != 2'd0;
  assign m_axis_tuser  = head.glyph_set;
  assign m_axis_tdata  = {6'd0, head.code_ok, head.scroll_request, head.pos_y,
                          head.pos_x, head.glyph_index};

  // queue never holds more than two results
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result queue count out of range");

  // input side stalls only with a full queue behind the input register
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (stage_valid_q && cnt_q == 2'd2 && !m_axis_tready))
    else $error("input stalled without a full result queue");

  // a held item is not lost while the queue is full
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_valid_q && !adv) |=> stage_valid_q)
    else $error("input register dropped a stalled item");

  // a clear puts the cursor at the window origin
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && stage_cmd_q) |=> (state_q.cursor_x == '0 && state_q.cursor_y == '0 && cnt_q == $past(cnt_q) - 2'($past(pop))))
    else $error("clear did not reset the cursor or produced a result");

endmodule
